/* rtl/aidq_pkg.sv */
// Shared types and constants for the alarm input debounce and event queue.
`timescale 1ns / 1ps
package aidq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int TIME_W      = 32;
	localparam int INTERVAL_W  = 16;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(4);

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// result queue at the output
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		KIND_PRESS   = 1'b0,
		KIND_RELEASE = 1'b1
	} kind_t;

	typedef struct packed {
		logic operation;
		logic pin_level;
	} in_item_t;

	typedef struct packed {
		logic              event_valid;
		logic              event_kind;
		logic [TIME_W-1:0] event_time;
		logic [PTR_W-1:0]  events_pending;
		logic              dropped;
	} out_item_t;

	typedef struct packed {
		logic              is_read;
		logic              push_en;
		logic              kind;
		logic [TIME_W-1:0] stamp;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic [TIME_W-1:0] stamp;
	} event_t;

endpackage

/* rtl/aidq_front.sv */
// Front end: tick counter, pin debounce and classification of each item into a command.
`timescale 1ns / 1ps
module aidq_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  aidq_pkg::in_item_t                   in_data,
	input  logic                                 accept,
	input  logic                                 cfg_wen,
	input  logic [aidq_pkg::INTERVAL_W-1:0]      cfg_wdata,
	output aidq_pkg::cmd_t                       cmd
);
	import aidq_pkg::*;

	logic [INTERVAL_W-1:0] interval_q;
	logic                  polling_q, polling_d;
	logic [1:0]            conf_q, conf_d;
	logic                  last_q, last_d;
	logic [INTERVAL_W-1:0] wait_q, wait_d;
	logic [TIME_W-1:0]     time_q, time_d;
	logic                  push_en;
	logic                  kind;

	always_comb begin
		polling_d = polling_q;
		conf_d    = conf_q;
		last_d    = last_q;
		wait_d    = wait_q;
		time_d    = time_q;
		push_en   = 1'b0;
		kind      = KIND_PRESS;
		if (in_data.operation == OP_TICK) begin
			time_d = time_q + 1'b1;
			last_d = in_data.pin_level;
			if (!polling_q) begin
				// falling edge: start polling, this tick is the first low sample
				if (last_q && !in_data.pin_level) begin
					polling_d = 1'b1;
					conf_d    = 2'd1;
					wait_d    = interval_q;
				end
			end else if (wait_q <= INTERVAL_W'(1)) begin
				if (!in_data.pin_level) begin
					if (conf_q == 2'd1) begin
						push_en = 1'b1;
						kind    = KIND_PRESS;
					end
					if (conf_q != 2'd2)
						conf_d = conf_q + 2'd1;
					wait_d = interval_q;
				end else begin
					if (conf_q != 2'd0) begin
						push_en = 1'b1;
						kind    = KIND_RELEASE;
					end
					polling_d = 1'b0;
					wait_d    = '0;
				end
			end else begin
				wait_d = wait_q - 1'b1;
			end
		end
	end

	assign cmd = '{is_read: (in_data.operation == OP_READ), push_en: push_en,
		kind: kind, stamp: time_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_wen) begin
			interval_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polling_q <= 1'b0;
			conf_q    <= 2'd0;
			last_q    <= 1'b1;
			wait_q    <= '0;
			time_q    <= '0;
		end else if (accept) begin
			polling_q <= polling_d;
			conf_q    <= conf_d;
			last_q    <= last_d;
			wait_q    <= wait_d;
			time_q    <= time_d;
		end
	end

endmodule

/* rtl/aidq_cmd_fifo.sv */
// Short command queue that decouples the front end from the event queue back end.
`timescale 1ns / 1ps
module aidq_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  aidq_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output logic           rd_valid,
	output aidq_pkg::cmd_t rd_data
);
	import aidq_pkg::*;

	cmd_t                slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/aidq_back.sv */
// Back end: timestamped event store, drop flag and the result queue.
`timescale 1ns / 1ps
module aidq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  aidq_pkg::cmd_t      cmd,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output aidq_pkg::out_item_t out_data
);
	import aidq_pkg::*;

	event_t              ev_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wp_q, rp_q, wp_d, rp_d;
	logic                drop_q, drop_d;
	logic                ev_full, ev_empty;
	logic                do_write, do_read;
	logic [PTR_W-1:0]    pend;
	logic                drop_rpt;

	// stage 2: memory read data arrives here
	logic                valid_s2;
	logic                hit_s2;
	logic [PTR_W-1:0]    pend_s2;
	logic                drop_s2;
	event_t              ev_s2;
	out_item_t           res_s2;

	// result queue
	out_item_t           oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic [OQ_CNT_W:0]   oq_use;
	logic                oq_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// take a command only if the result queue can hold it and the one in flight
	assign oq_use   = {1'b0, oq_cnt_q} + (OQ_CNT_W + 1)'(valid_s2);
	assign cmd_take = cmd_valid && (oq_use < (OQ_CNT_W + 1)'(OQ_DEPTH));

	assign ev_full  = (next_ptr(wp_q) == rp_q);
	assign ev_empty = (wp_q == rp_q);
	assign do_write = cmd_take && !cmd.is_read && cmd.push_en && !ev_full;
	assign do_read  = cmd_take && cmd.is_read && !ev_empty;

	always_comb begin
		wp_d     = do_write ? next_ptr(wp_q) : wp_q;
		rp_d     = do_read ? next_ptr(rp_q) : rp_q;
		drop_d   = drop_q;
		drop_rpt = drop_q;
		if (cmd.is_read) begin
			drop_d = 1'b0;
		end else begin
			// a full queue drops the new event and flags it
			if (cmd.push_en && ev_full)
				drop_d = 1'b1;
			drop_rpt = drop_d;
		end
		if (wp_d >= rp_d)
			pend = wp_d - rp_d;
		else
			pend = PTR_W'(wp_d + PTR_W'(QUEUE_DEPTH) - rp_d);
	end

	always_ff @(posedge clk) begin
		if (do_write)
			ev_mem[wp_q] <= '{kind: cmd.kind, stamp: cmd.stamp};
		if (do_read)
			ev_s2 <= ev_mem[rp_q];
		if (cmd_take) begin
			hit_s2  <= do_read;
			pend_s2 <= pend;
			drop_s2 <= drop_rpt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			drop_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= cmd_take;
			if (cmd_take) begin
				wp_q   <= wp_d;
				rp_q   <= rp_d;
				drop_q <= drop_d;
			end
		end
	end

	always_comb begin
		res_s2.event_valid    = hit_s2;
		res_s2.event_kind     = hit_s2 ? ev_s2.kind : 1'b0;
		res_s2.event_time     = hit_s2 ? ev_s2.stamp : '0;
		res_s2.events_pending = pend_s2;
		res_s2.dropped        = drop_s2;
	end

	assign empty    = (oq_cnt_q == '0);
	assign oq_pop   = pop && !empty;
	assign out_data = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (valid_s2)
			oq_q[oq_wr_q] <= res_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s2)
				oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			if (oq_pop)
				oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			if (valid_s2 && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (!valid_s2 && oq_pop)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/alarm_input_debounce_event_queue.sv */
// Top level of the alarm input debounce and timestamped event queue.
`timescale 1ns / 1ps
// Takes one item per clock while full is low and gives one result per item, in
// order. Tick items advance the tick counter and sample the active-low pin; read
// items pop one press or release event. A taken item passes through the command
// queue and waits for room in the result queue before the event store access
// (single port, one write or one registered read per cycle), after which it is
// written into the four-entry result queue. full rises only when the result side
// stalls long enough to fill both queues. The event store holds 31 events; further
// events are dropped and reported through dropped until the next read. No clearing
// pass is needed after reset. sample_interval may be written only while no items
// are in flight; a new value takes effect at the next pin sample.
module alarm_input_debounce_event_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  aidq_pkg::in_item_t              in_data,
	output logic                            empty,
	input  logic                            pop,
	output aidq_pkg::out_item_t             out_data,
	input  logic                            cfg_wen,
	input  logic [aidq_pkg::INTERVAL_W-1:0] cfg_wdata
);
	import aidq_pkg::*;

	logic accept;
	cmd_t front_cmd;
	logic cq_valid;
	cmd_t cq_cmd;
	logic cq_take;

	assign accept = push && !full;

	aidq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.accept    (accept),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (front_cmd)
	);

	aidq_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_cmd),
		.full     (full),
		.rd_en    (cq_take),
		.rd_valid (cq_valid),
		.rd_data  (cq_cmd)
	);

	aidq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cq_valid),
		.cmd       (cq_cmd),
		.cmd_take  (cq_take),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data)
	);

endmodule

/* verif/tb_alarm_input_debounce_event_queue.sv */
// Testbench for the alarm input debounce and event queue: random and directed items, self-checking.
`timescale 1ns / 1ps
module tb_alarm_input_debounce_event_queue;
	import aidq_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int LONG_STALL   = 200;
	localparam int MAX_REPORTS  = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	in_item_t              in_data = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	out_item_t             out_data;
	logic                  cfg_wen = 1'b0;
	logic [INTERVAL_W-1:0] cfg_wdata = '0;

	alarm_input_debounce_event_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_data   (in_data),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// debounce state kept alongside the block
	logic [INTERVAL_W-1:0] sample_interval_cfg = INTERVAL_RESET;
	logic                  poll_active = 1'b0;
	logic [1:0]            low_samples = 2'd0;
	logic                  prev_level = 1'b1;
	logic [INTERVAL_W-1:0] sample_wait = '0;
	logic [TIME_W-1:0]     tick_count = '0;
	logic                  lost_events = 1'b0;
	event_t                alarm_events[$];

	in_item_t  items_to_send[$];
	out_item_t results_due[$];

	int   error_count = 0;
	int   cycle_count = 0;
	int   send_idle_max = 0;
	int   recv_idle_max = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic want_long_stall = 1'b0;
	logic long_stall_done = 1'b0;
	int   stall_cycles = 0;

	function automatic void store_event(kind_t kind);
		event_t ev;
		if (alarm_events.size() == QUEUE_DEPTH - 1) begin
			lost_events = 1'b1;
			return;
		end
		ev.kind = kind;
		ev.stamp = tick_count;
		alarm_events.push_back(ev);
	endfunction

	function automatic void sample_pin(logic pin);
		if (!pin) begin
			if (low_samples == 2'd1)
				store_event(KIND_PRESS);
			if (low_samples < 2'd2)
				low_samples++;
			sample_wait = sample_interval_cfg;
		end else begin
			if (low_samples != 2'd0)
				store_event(KIND_RELEASE);
			poll_active = 1'b0;
			sample_wait = '0;
		end
	endfunction

	function automatic out_item_t predict_alarm_result(in_item_t item);
		out_item_t res;
		event_t    ev;
		res = '0;
		if (item.operation == OP_TICK) begin
			tick_count++;
			if (!poll_active) begin
				// falling edge starts polling and samples on the same tick
				if (prev_level && !item.pin_level) begin
					poll_active = 1'b1;
					low_samples = 2'd0;
					sample_pin(item.pin_level);
				end
			end else if (sample_wait <= 1) begin
				sample_pin(item.pin_level);
			end else begin
				sample_wait--;
			end
			prev_level = item.pin_level;
			res.dropped = lost_events;
		end else begin
			if (alarm_events.size() > 0) begin
				ev = alarm_events.pop_front();
				res.event_valid = 1'b1;
				res.event_kind = ev.kind;
				res.event_time = ev.stamp;
			end
			res.dropped = lost_events;
			lost_events = 1'b0;
		end
		res.events_pending = PTR_W'(alarm_events.size());
		return res;
	endfunction

	function automatic void check_field(string name, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// sample both handshakes, predict accepted items, check accepted results
	always @(posedge clk) begin
		out_item_t want;
		in_fire <= arst_n && push && !full;
		out_fire <= arst_n && pop && !empty;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
			end else begin
				want = results_due.pop_front();
				check_field("event_valid", TIME_W'(want.event_valid),
					TIME_W'(out_data.event_valid));
				check_field("event_kind", TIME_W'(want.event_kind),
					TIME_W'(out_data.event_kind));
				check_field("event_time", want.event_time, out_data.event_time);
				check_field("events_pending", TIME_W'(want.events_pending),
					TIME_W'(out_data.events_pending));
				check_field("dropped", TIME_W'(want.dropped), TIME_W'(out_data.dropped));
			end
		end
		if (arst_n && push && !full)
			results_due.push_back(predict_alarm_result(in_data));
	end

	// sender: hold an item until its transfer, then wait the drawn gap
	always @(negedge clk) begin
		if (!push || in_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (items_to_send.size() > 0) begin
				in_data <= items_to_send.pop_front();
				push <= 1'b1;
				send_gap = $urandom_range(0, send_idle_max);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: gap after each transfer, one long hold-off on request
	always @(negedge clk) begin
		if (out_fire)
			recv_gap = $urandom_range(0, recv_idle_max);
		if (want_long_stall && !long_stall_done && stall_cycles < LONG_STALL) begin
			stall_cycles++;
			pop <= 1'b0;
		end else begin
			if (want_long_stall)
				long_stall_done = 1'b1;
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_item(op_t op, logic pin);
		in_item_t item;
		item.operation = op;
		item.pin_level = pin;
		items_to_send.push_back(item);
	endtask

	task automatic write_interval(logic [INTERVAL_W-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		sample_interval_cfg = value;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (items_to_send.size() > 0 || push || results_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly press/release pulses with random lengths, plus reads and noise
	task automatic add_random_items(int count, int read_pct);
		int target;
		int span;
		int low_len;
		int high_len;
		int r;
		target = items_to_send.size() + count;
		span = (sample_interval_cfg > 8) ? 8 : int'(sample_interval_cfg);
		while (items_to_send.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < read_pct) begin
				add_item(OP_READ, 1'($urandom_range(0, 1)));
			end else if (r < read_pct + 10) begin
				add_item(OP_TICK, 1'($urandom_range(0, 1)));
			end else begin
				low_len = $urandom_range(1, 3 * span + 4);
				high_len = $urandom_range(1, span + 3);
				add_item(OP_TICK, 1'b1);
				for (int i = 0; i < low_len; i++) begin
					if ($urandom_range(0, 99) < read_pct)
						add_item(OP_READ, 1'($urandom_range(0, 1)));
					// an occasional glitch inside the low stretch
					add_item(OP_TICK, $urandom_range(0, 19) == 0);
				end
				for (int i = 0; i < high_len; i++)
					add_item(OP_TICK, 1'b1);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset interval of 4
		send_idle_max = 3;
		recv_idle_max = 3;
		add_item(OP_READ, 1'b0);
		add_item(OP_TICK, 1'b1);
		add_item(OP_TICK, 1'b0);
		add_item(OP_TICK, 1'b1);
		add_item(OP_TICK, 1'b0);
		add_item(OP_TICK, 1'b0);
		add_item(OP_TICK, 1'b0);
		repeat (4) add_item(OP_TICK, 1'b0);
		repeat (4) add_item(OP_TICK, 1'b1);
		// bounce: one low sample, then high at the next sample
		add_item(OP_TICK, 1'b0);
		repeat (4) add_item(OP_TICK, 1'b1);
		add_item(OP_READ, 1'b1);
		add_item(OP_READ, 1'b0);
		add_item(OP_READ, 1'b1);
		add_item(OP_READ, 1'b0);
		wait_idle();

		write_interval(16'd0);
		send_idle_max = 11;
		recv_idle_max = 11;
		add_random_items(200, 25);
		wait_idle();

		// few reads: fill the store and drop events
		write_interval(16'd1);
		send_idle_max = 0;
		recv_idle_max = 0;
		add_random_items(250, 3);
		wait_idle();

		write_interval(16'd2);
		send_idle_max = 11;
		recv_idle_max = 0;
		add_random_items(200, 60);
		wait_idle();

		// long receiver hold-off while the sender keeps offering
		write_interval(16'd3);
		send_idle_max = 0;
		recv_idle_max = 5;
		want_long_stall = 1'b1;
		add_random_items(100, 30);
		wait_idle();

		write_interval(16'd7);
		send_idle_max = 0;
		recv_idle_max = 11;
		add_random_items(230, 30);
		wait_idle();

		write_interval(16'hFFFF);
		send_idle_max = 5;
		recv_idle_max = 5;
		add_random_items(50, 40);
		wait_idle();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* alarm_input_debounce_event_queue.f */
rtl/aidq_pkg.sv
rtl/aidq_front.sv
rtl/aidq_cmd_fifo.sv
rtl/aidq_back.sv
rtl/alarm_input_debounce_event_queue.sv
verif/tb_alarm_input_debounce_event_queue.sv
